// File: rtl/core/apc_pkg.sv
// Package: shared constants, sequencer state type and divider status word.
package apc_pkg;

    // Default width of the candidate number
    localparam int NUMBER_WIDTH_DEFAULT = 20;

    // Width of the partner field and its saturation value
    localparam int PARTNER_WIDTH = 22;
    localparam logic [PARTNER_WIDTH-1:0] PARTNER_MAX = {PARTNER_WIDTH{1'b1}};

    // Headroom of the divisor sums over the number width
    localparam int SUM_HEADROOM = 3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PASS_END,
        ST_DONE
    } apc_state_t;

    // Status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } apc_div_status_t;

endpackage

// File: rtl/core/apc_if.sv
// Channel interfaces: candidate word in, result word out.
interface apc_cand_if #(
    parameter int NUMBER_WIDTH = apc_pkg::NUMBER_WIDTH_DEFAULT
);
    logic                    valid;
    logic                    ready;
    logic [NUMBER_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface apc_res_if;
    import apc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [PARTNER_WIDTH-1:0] partner;
    logic                     is_pair;

    modport source (output valid, output partner, output is_pair, input ready);
    modport sink   (input valid, input partner, input is_pair, output ready);
endinterface

// File: rtl/core/apc_divider.sv
// Restoring divider: one quotient bit per cycle, quotient and remainder held after done.
module apc_divider #(
    parameter int OPW = 23
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [OPW-1:0]           dividend,
    input  logic [OPW-1:0]           divisor,
    output apc_pkg::apc_div_status_t status,
    output logic [OPW-1:0]           quotient,
    output logic [OPW-1:0]           remainder
);
    import apc_pkg::*;

    localparam int CW = $clog2(OPW + 1);

    logic [OPW-1:0] rem_reg, rem_next;
    logic [OPW-1:0] quo_reg, quo_next;
    logic [OPW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [OPW:0]   trial;
    logic           fits;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb
    begin
        trial = {rem_reg, quo_reg[OPW-1]};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // Advance one step per cycle while busy
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CW'(OPW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = trial[OPW-1:0] - dsr_reg;
            end
            else
            begin
                rem_next = trial[OPW-1:0];
            end
            quo_next = {quo_reg[OPW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

// File: rtl/core/amicable_pair_check_core.sv
// Top level: amicable pair test by aliquot sum, trial division on one shared divider.
//
//   channel  role   fields                   word
//   -------  -----  -----------------------  -------------------------
//   cand     sink   candidate[NW-1:0]        one number a per word
//   res      source partner[21:0], is_pair   one result word per input
//
// Each divisor trial starts the shared bit-serial divider, waits for its done
// and adds i and n / i on a zero remainder; a word runs trials up to isqrt(a),
// and up to isqrt(b) in a second pass when b exceeds a; none for a below 2.
// cand.ready is high only while the sequencer is idle; the result sits in an
// output register, so the next word is taken while a result waits.
// Reset is asynchronous, active low, and clears the sequencer and res.valid.
module amicable_pair_check_core #(
    parameter int NUMBER_WIDTH = apc_pkg::NUMBER_WIDTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    apc_cand_if.sink cand,
    apc_res_if.source res
);
    import apc_pkg::*;

    localparam int NW = NUMBER_WIDTH;
    localparam int BW = NW + SUM_HEADROOM;
    localparam int AW = BW + SUM_HEADROOM;
    localparam int XW = (AW > PARTNER_WIDTH) ? AW : PARTNER_WIDTH;

    apc_state_t state_reg, state_next;

    logic [NW-1:0]            a_reg, a_next;
    logic [BW-1:0]            n_reg, n_next;
    logic [BW-1:0]            i_reg, i_next;
    logic [AW-1:0]            sum_reg, sum_next;
    logic                     pass_reg, pass_next;
    logic [PARTNER_WIDTH-1:0] partner_reg, partner_next;
    logic                     pair_reg, pair_next;
    logic                     out_valid_reg, out_valid_next;
    logic [PARTNER_WIDTH-1:0] res_partner_reg, res_partner_next;
    logic                     res_pair_reg, res_pair_next;

    logic                     div_start;
    apc_div_status_t          div_status;
    logic [BW-1:0]            div_quo;
    logic [BW-1:0]            div_rem;

    logic                     trial_stop;
    logic [AW-1:0]            term_q;
    logic [XW-1:0]            sum_ext;
    logic                     out_free;

    // Shared divider: n / i for every trial divisor
    apc_divider #(
        .OPW(BW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (i_reg),
        .status   (div_status),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    // Stop once i exceeds n / i; pair divisor q counts only when distinct
    always_comb
    begin
        trial_stop = (div_quo < i_reg);
        term_q     = (div_quo != i_reg) ? AW'(div_quo) : '0;
        sum_ext    = XW'(sum_reg);
        out_free   = !out_valid_reg || res.ready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cand.valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (n_reg < BW'(2))
                begin
                    state_next = ST_PASS_END;
                end
                else
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = trial_stop ? ST_PASS_END : ST_DIV_START;
                end
            end
            ST_PASS_END:
            begin
                if (!pass_reg && (AW'(a_reg) < sum_reg))
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        a_next           = a_reg;
        n_next           = n_reg;
        i_next           = i_reg;
        sum_next         = sum_reg;
        pass_next        = pass_reg;
        partner_next     = partner_reg;
        pair_next        = pair_reg;
        res_partner_next = res_partner_reg;
        res_pair_next    = res_pair_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        div_start        = 1'b0;
        cand.ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cand.ready = 1'b1;
                a_next     = cand.candidate;
                n_next     = BW'(cand.candidate);
                pass_next  = 1'b0;
            end
            ST_SETUP:
            begin
                i_next = BW'(2);
                if (n_reg < BW'(2))
                begin
                    sum_next = '0;
                end
                else
                begin
                    sum_next = AW'(1);
                end
            end
            ST_DIV_START:
            begin
                div_start = 1'b1;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done && !trial_stop)
                begin
                    if (div_rem == '0)
                    begin
                        sum_next = sum_reg + AW'(i_reg) + term_q;
                    end
                    i_next = i_reg + BW'(1);
                end
            end
            ST_PASS_END:
            begin
                if (!pass_reg)
                begin
                    // Saturate the partner field; keep the sum, cut to BW bits, for pass two
                    if (sum_ext > XW'(PARTNER_MAX))
                    begin
                        partner_next = PARTNER_MAX;
                    end
                    else
                    begin
                        partner_next = sum_ext[PARTNER_WIDTH-1:0];
                    end
                    pair_next = 1'b0;
                    n_next    = sum_reg[BW-1:0];
                    pass_next = 1'b1;
                end
                else
                begin
                    pair_next = (sum_reg == AW'(a_reg));
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_partner_next = partner_reg;
                    res_pair_next    = pair_reg;
                    out_valid_next   = 1'b1;
                end
            end
            default:
            begin
                cand.ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pass_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pass_reg      <= pass_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg           <= a_next;
        n_reg           <= n_next;
        i_reg           <= i_next;
        sum_reg         <= sum_next;
        partner_reg     <= partner_next;
        pair_reg        <= pair_next;
        res_partner_reg <= res_partner_next;
        res_pair_reg    <= res_pair_next;
    end

    assign res.valid   = out_valid_reg;
    assign res.partner = res_partner_reg;
    assign res.is_pair = res_pair_reg;

endmodule

// File: rtl/core/apc_checker.sv
// Port checker for the amicable pair core, with its bind statement.
module apc_checker #(
    parameter int PW = 22
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [PW-1:0] partner,
    input logic          is_pair
);
    logic [1:0] pend_reg, pend_next;

    // Count words taken but not yet answered
    always_comb
    begin
        pend_next = pend_reg + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(partner) && $stable(is_pair))
        else $error("result word changed or dropped while stalled");

    // Drop ready for the word after a take
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while the first is in work");

    // No result without a word taken before it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result word with no candidate outstanding");

    // At most one word in work and one waiting
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many words outstanding");

endmodule

bind amicable_pair_check_core apc_checker #(
    .PW(apc_pkg::PARTNER_WIDTH)
) u_apc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (cand.valid),
    .in_ready (cand.ready),
    .out_valid(res.valid),
    .out_ready(res.ready),
    .partner  (res.partner),
    .is_pair  (res.is_pair)
);
